// File: design/olist_pkg.sv
package olist_pkg;

  // List geometry.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Common width for comparing positions, counts and indexes.
  localparam int CMP_W    = ((CNT_W > 5) ? CNT_W : 5) + 1;

  localparam int VAL_W    = 32;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  typedef enum logic [2:0] {
    MD_INS_FRONT = 3'd0,
    MD_INS_BACK  = 3'd1,
    MD_INS_AT    = 3'd2,
    MD_DEL_FRONT = 3'd3,
    MD_DEL_BACK  = 3'd4,
    MD_DEL_AT    = 3'd5,
    MD_DEL_VALUE = 3'd6,
    MD_SEARCH    = 3'd7
  } olist_mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } olist_status_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] wval;
  } olist_ctl_t;

endpackage

// File: design/olist_cell.sv
module olist_cell
  import olist_pkg::*;
(
  input  logic             clk,
  input  olist_ctl_t       ctl,
  input  logic [IDX_W-1:0] my_index,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  output logic [VAL_W-1:0] data,
  output logic             eq
);

  // Compare against the key, or shift toward the back or the front.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      eq <= (data == ctl.wval);
    end
    if (ctl.ins) begin
      if (my_index == ctl.idx) begin
        data <= ctl.wval;
      end else if (my_index > ctl.idx) begin
        data <= left_data;
      end
    end else if (ctl.del) begin
      if (my_index >= ctl.idx) begin
        data <= right_data;
      end
    end
  end

endmodule

// File: design/ordered_list_engine_core.sv
// Ordered list engine: a bounded list of up to CAPACITY signed 32-bit
// values held in a row of cells, each cell owning one list slot.
// Requests arrive on the s_ side (mode, position, value); every request
// yields exactly one result word on the m_ side (status, new length,
// found or removed position, removed value).
// A request is taken only while the sequencer is idle. The following
// cycle every cell compares its entry with the key; the cycle after
// that the first match is picked and the request is decided; for an
// insert or delete the cells from the target slot onward move one
// place in the same edge that loads the result into the output
// register. A new request is not taken before the compare pass and
// the decide step of the previous one are through.
// If the receiver stalls with a result still held, the decide step
// waits and the cells keep their contents until the output register
// frees up; a new request is never taken in that time.
// Reset empties the list and drops any pending result; cell contents
// are not cleared, since only slots below the length are ever read.
module ordered_list_engine_core
  import olist_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // mode[2:0], position[7:3], value[39:8]
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[2:0], length[7:3], found_position[12:8], removed_value[44:13]
  output logic [OUT_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t           state;
  olist_mode_t      req_mode;
  logic [4:0]       req_pos;
  logic [VAL_W-1:0] req_value;
  logic [CNT_W-1:0] cnt;

  olist_status_t    out_status;
  logic [4:0]       out_len;
  logic [4:0]       out_fpos;
  logic [VAL_W-1:0] out_rem;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_eq;
  olist_ctl_t       ctl;

  // Decision signals.
  olist_status_t    st;
  logic             do_ins;
  logic             do_del;
  logic [IDX_W-1:0] idx;
  logic [CMP_W-1:0] fpos_w;
  logic [VAL_W-1:0] rem;
  logic [CNT_W-1:0] cnt_next;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] pos_m1;
  logic [CMP_W-1:0] len_x;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] first_oh;
  logic [IDX_W-1:0] fidx;
  logic             any_match;
  logic             out_free;
  logic             s_acc;
  logic             exec_go;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign exec_go  = (state == S_EXEC) && out_free;

  // Live entries that hold the key, and the first of them.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = cell_eq[i] && (CMP_W'(i) < cnt_x);
    end
    first_oh  = match & (~match + 1'b1);
    any_match = |match;
    fidx      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_oh[i]) begin
        fidx = fidx | IDX_W'(i);
      end
    end
  end

  assign cnt_x  = {{(CMP_W-CNT_W){1'b0}}, cnt};
  assign pos_x  = {{(CMP_W-5){1'b0}}, req_pos};
  assign pos_m1 = pos_x - 1'b1;
  assign len_x  = {{(CMP_W-CNT_W){1'b0}}, cnt_next};

  // Decide the request from the mode, the length and the match vector.
  always_comb begin
    st     = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    fpos_w = '0;
    case (req_mode)
      MD_INS_FRONT, MD_INS_BACK, MD_INS_AT: begin
        if (req_mode == MD_INS_AT && (pos_x == '0 || pos_x > cnt_x + 1'b1)) begin
          st = ST_BADPOS;
        end else if (cnt_x == CMP_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
          if (req_mode == MD_INS_BACK) begin
            idx = cnt_x[IDX_W-1:0];
          end else if (req_mode == MD_INS_AT) begin
            idx = pos_m1[IDX_W-1:0];
          end
        end
      end
      MD_DEL_FRONT, MD_DEL_BACK: begin
        if (cnt == '0) begin
          st = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          if (req_mode == MD_DEL_BACK) begin
            idx = IDX_W'(cnt_x - 1'b1);
          end
        end
      end
      MD_DEL_AT: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          idx    = pos_m1[IDX_W-1:0];
        end
      end
      MD_DEL_VALUE: begin
        if (cnt == '0) begin
          st = ST_EMPTY;
        end else if (!any_match) begin
          st = ST_NOTFOUND;
        end else begin
          do_del = 1'b1;
          idx    = fidx;
        end
      end
      MD_SEARCH: begin
        if (!any_match) begin
          st = ST_NOTFOUND;
        end else begin
          fpos_w = {{(CMP_W-IDX_W){1'b0}}, fidx} + 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    if (do_del) begin
      fpos_w = {{(CMP_W-IDX_W){1'b0}}, idx} + 1'b1;
    end
    rem      = do_del ? cell_data[idx] : '0;
    cnt_next = do_ins ? cnt + 1'b1 : (do_del ? cnt - 1'b1 : cnt);
  end

  // Broadcast to the cells; shifts happen only when the result is stored.
  always_comb begin
    ctl.cmp  = (state == S_CMP);
    ctl.ins  = exec_go && do_ins;
    ctl.del  = exec_go && do_del;
    ctl.idx  = idx;
    ctl.wval = req_value;
  end

  // Row of cells, each linked to its neighbors; the first takes the request value, the last its own entry.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = req_value;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    olist_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .my_index   (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .eq         (cell_eq[g])
    );
  end

  // Sequencer, request capture, length and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            state    <= S_IDLE;
            cnt      <= cnt_next;
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (s_acc) begin
      req_mode  <= olist_mode_t'(s_tdata[2:0]);
      req_pos   <= s_tdata[7:3];
      req_value <= s_tdata[39:8];
    end
    if (exec_go) begin
      out_status <= st;
      out_len    <= len_x[4:0];
      out_fpos   <= fpos_w[4:0];
      out_rem    <= rem;
    end
  end

  assign m_tdata = {3'b000, out_rem, out_fpos, out_len, out_status};

`ifndef SYNTHESIS
  // The list never holds more entries than there are cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= CMP_W'(CAPACITY))
    else $error("list length exceeds capacity");

  // An accepted request always moves on to the compare pass.
  a_acc_cmp: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> state == S_CMP)
    else $error("accepted request did not start the compare pass");

  // A freshly loaded result reports the length now held.
  a_len_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[7:3] == cnt_x[4:0])
    else $error("reported length disagrees with the list");

  // While the decide step waits on a stalled receiver the list holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !out_free) |=> cnt == $past(cnt))
    else $error("list changed while the result was stalled");
`endif

endmodule
